// ----- design/tbi_pkg.sv -----
// ----------------------------------------------------------------------------
// tbi_pkg - shared types and widths for the tetrahedral interpolation unit
// Request and result formats, datapath widths, unit commands and sequencer
// states.
// ----------------------------------------------------------------------------
package tbi_pkg;

  localparam int COORD_BITS = 24;
  localparam int FIELD_BITS = 24;
  localparam int CUT_BITS   = 48;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int DET_W   = 3 * COORD_BITS + 6;
  localparam int MB_W    = (EDGE_W > FIELD_BITS) ? EDGE_W : FIELD_BITS;
  localparam int ACC_W   = DET_W + MB_W + 2;
  localparam int DIGIT_W = 8;
  localparam int NDIG    = (MB_W + DIGIT_W - 1) / DIGIT_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [ACC_W-1:0] LIM_POS = ACC_W'({(FIELD_BITS-1){1'b1}});
  localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'({1'b1, {(FIELD_BITS-1){1'b0}}});

  typedef struct packed {
    logic                         req_type;
    logic [1:0]                   vertex_slot;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [FIELD_BITS-1:0] fld_x;
    logic signed [FIELD_BITS-1:0] fld_y;
    logic signed [FIELD_BITS-1:0] fld_z;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] field_x;
    logic signed [FIELD_BITS-1:0] field_y;
    logic signed [FIELD_BITS-1:0] field_z;
    logic                         inside_res;
    logic                         degenerate;
    logic                         saturated;
  } res_t;

  typedef struct packed {
    logic                    start;
    logic                    keep;
    logic                    sub;
    logic signed [ACC_W-1:0] init;
    logic signed [DET_W-1:0] a;
    logic signed [MB_W-1:0]  b;
  } mac_cmd_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [DET_W-1:0] den;
  } div_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGES, ST_MAC_GO, ST_MAC_WAIT, ST_DET_END, ST_DIV_GO, ST_DIV_WAIT, ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PH_COF_A, PH_COF_B, PH_TERM
  } phase_t;

endpackage

// ----- design/tbi_mac.sv -----
// ----------------------------------------------------------------------------
// tbi_mac - digit-serial multiply-accumulate unit
// acc = (keep ? acc : init) +/- a * b, one 8-bit digit of |b| per cycle.
// ----------------------------------------------------------------------------
module tbi_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  tbi_pkg::mac_cmd_t               cmd,
  output logic signed [tbi_pkg::ACC_W-1:0] acc,
  output logic                            done
);
  import tbi_pkg::*;

  localparam int CW = $clog2(NDIG + 1);

  logic                    busy;
  logic [CW-1:0]           cnt;
  logic signed [ACC_W-1:0] a_sh;
  logic [MB_W-1:0]         b_rem;
  logic [MB_W-1:0]         b_mag;
  logic signed [ACC_W-1:0] a_ext;
  logic signed [ACC_W+DIGIT_W:0] prod;

  always_comb begin
    b_mag = cmd.b[MB_W-1] ? MB_W'(-cmd.b) : MB_W'(cmd.b);
    a_ext = ACC_W'(cmd.a);
    prod  = a_sh * $signed({1'b0, b_rem[DIGIT_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CW'(NDIG);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc   <= cmd.keep ? acc : cmd.init;
      a_sh  <= (cmd.sub ^ cmd.b[MB_W-1]) ? -a_ext : a_ext;
      b_rem <= b_mag;
    end else if (busy) begin
      acc   <= acc + $signed(prod[ACC_W-1:0]);
      a_sh  <= a_sh <<< DIGIT_W;
      b_rem <= b_rem >> DIGIT_W;
    end
  end

endmodule

// ----- design/tbi_div.sv -----
// ----------------------------------------------------------------------------
// tbi_div - restoring divider, one quotient bit per cycle
// Returns the quotient magnitude and its sign for truncation toward zero.
// ----------------------------------------------------------------------------
module tbi_div (
  input  logic                     clk,
  input  logic                     rst,
  input  tbi_pkg::div_cmd_t        cmd,
  output logic [tbi_pkg::ACC_W-1:0] quo,
  output logic                     neg,
  output logic                     done
);
  import tbi_pkg::*;

  localparam int CW = $clog2(ACC_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [ACC_W-1:0] num_sh;
  logic [DET_W-1:0] den_mag;
  logic [DET_W-1:0] rem;
  logic [DET_W:0]   trial;
  logic [DET_W:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem, num_sh[ACC_W-1]};
    diff  = trial - {1'b0, den_mag};
    qbit  = trial >= {1'b0, den_mag};
  end

  assign quo = num_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CW'(ACC_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num_sh  <= cmd.num[ACC_W-1] ? ACC_W'(-cmd.num) : ACC_W'(cmd.num);
      den_mag <= cmd.den[DET_W-1] ? DET_W'(-cmd.den) : DET_W'(cmd.den);
      rem     <= '0;
      neg     <= cmd.num[ACC_W-1] ^ cmd.den[DET_W-1];
    end else if (busy) begin
      rem    <= qbit ? diff[DET_W-1:0] : trial[DET_W-1:0];
      num_sh <= {num_sh[ACC_W-2:0], qbit};
    end
  end

endmodule

// ----- design/tetra_barycentric_interp_unit.sv -----
// ----------------------------------------------------------------------------
// tetra_barycentric_interp_unit - tetrahedral barycentric field interpolation
// A load request is written to its vertex slot and busy stays low. A query
// keeps busy high until its result strobe, and a degenerate tetrahedron ends
// it after the volume determinant; one query at a time, set
// by the shared digit-serial MAC and the bit-per-cycle divider.
// The result strobe lasts one cycle and cannot be stalled.
// Synchronous reset clears the sequencer and the volume cut; vertices need loading.
// ----------------------------------------------------------------------------
module tetra_barycentric_interp_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tbi_pkg::req_t                 req,
  input  logic                          cfg_we,
  input  logic [tbi_pkg::CUT_BITS-1:0]  cfg_data,
  output logic                          done,
  output tbi_pkg::res_t                 result
);
  import tbi_pkg::*;

  state_t state, state_next;
  phase_t phase;

  logic [CUT_BITS-1:0]          cut;
  logic signed [COORD_BITS-1:0] vp [4][3];
  logic signed [FIELD_BITS-1:0] vf [4][3];
  logic signed [COORD_BITS-1:0] qp [3];
  logic signed [COORD_BITS-1:0] pp [4][3];
  logic signed [EDGE_W-1:0]     e [3][3];
  logic signed [EDGE_W-1:0]     e_next [3][3];
  logic signed [DET_W-1:0]      s_reg, det_run, dv;
  logic signed [DET_W-1:0]      di [4];
  logic signed [FIELD_BITS-1:0] fo [3];
  logic [2:0] det_idx;
  logic [1:0] cof, comp, vtx, jj, kk, dsel;
  logic       fmode, in_tet, sat, degen;

  mac_cmd_t                mac_cmd;
  div_cmd_t                div_cmd;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done;
  logic [ACC_W-1:0]        quo;
  logic                    quo_neg, div_done;

  logic [ACC_W-1:0]             acc_abs;
  logic                         degen_now;
  logic signed [FIELD_BITS-1:0] clip_val;
  logic                         clip_sat;

  tbi_mac u_mac (.clk(clk), .rst(rst), .cmd(mac_cmd), .acc(acc), .done(mac_done));
  tbi_div u_div (.clk(clk), .rst(rst), .cmd(div_cmd), .quo(quo), .neg(quo_neg),
                 .done(div_done));

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int k = 0; k < 3; k++) begin
        pp[v][k] = (det_idx == 3'(v + 1)) ? qp[k] : vp[v][k];
      end
    end
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        e_next[c][k] = EDGE_W'(pp[c+1][k]) - EDGE_W'(pp[0][k]);
      end
    end
  end

  always_comb begin
    unique case (cof)
      2'd0:    begin jj = 2'd1; kk = 2'd2; end
      2'd1:    begin jj = 2'd2; kk = 2'd0; end
      default: begin jj = 2'd0; kk = 2'd1; end
    endcase
    dsel      = 2'(det_idx - 3'd1);
    acc_abs   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    degen_now = acc_abs <= ACC_W'(cut);
    if (quo_neg) begin
      clip_sat = quo > LIM_NEG;
      clip_val = clip_sat ? $signed({1'b1, {(FIELD_BITS-1){1'b0}}})
                          : $signed(-quo[FIELD_BITS-1:0]);
    end else begin
      clip_sat = quo > LIM_POS;
      clip_val = clip_sat ? $signed({1'b0, {(FIELD_BITS-1){1'b1}}})
                          : $signed(quo[FIELD_BITS-1:0]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start && req.req_type == REQ_QUERY) state_next = ST_EDGES;
      ST_EDGES:    state_next = ST_MAC_GO;
      ST_MAC_GO:   state_next = ST_MAC_WAIT;
      ST_MAC_WAIT: begin
        if (mac_done) begin
          if (fmode) state_next = (vtx == 2'd3) ? ST_DIV_GO : ST_MAC_GO;
          else if (phase == PH_TERM && cof == 2'd2) state_next = ST_DET_END;
          else state_next = ST_MAC_GO;
        end
      end
      ST_DET_END: begin
        if (det_idx == 3'd0 && degen_now) state_next = ST_RESULT;
        else if (det_idx == 3'd4) state_next = ST_MAC_GO;
        else state_next = ST_EDGES;
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = (comp == 2'd2) ? ST_RESULT : ST_MAC_GO;
      ST_RESULT:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = state != ST_IDLE;
    done    = state == ST_RESULT;
    result.field_x    = fo[0];
    result.field_y    = fo[1];
    result.field_z    = fo[2];
    result.inside_res = in_tet && !degen;
    result.degenerate = degen;
    result.saturated  = sat;
    mac_cmd.start = state == ST_MAC_GO;
    mac_cmd.keep  = 1'b0;
    mac_cmd.sub   = 1'b0;
    mac_cmd.init  = '0;
    mac_cmd.a     = s_reg;
    mac_cmd.b     = MB_W'(e[0][cof]);
    if (fmode) begin
      mac_cmd.keep = vtx != 2'd0;
      mac_cmd.a    = di[vtx];
      mac_cmd.b    = MB_W'(vf[vtx][comp]);
    end else begin
      unique case (phase)
        PH_COF_A: begin
          mac_cmd.a = DET_W'(e[1][jj]);
          mac_cmd.b = MB_W'(e[2][kk]);
        end
        PH_COF_B: begin
          mac_cmd.keep = 1'b1;
          mac_cmd.sub  = 1'b1;
          mac_cmd.a    = DET_W'(e[1][kk]);
          mac_cmd.b    = MB_W'(e[2][jj]);
        end
        default: mac_cmd.init = ACC_W'(det_run);
      endcase
    end
    div_cmd.start = state == ST_DIV_GO;
    div_cmd.num   = acc;
    div_cmd.den   = dv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cut     <= '0;
      phase   <= PH_COF_A;
      det_idx <= '0;
      cof     <= '0;
      comp    <= '0;
      vtx     <= '0;
      fmode   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) cut <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (req.req_type == REQ_LOAD) begin
              vp[req.vertex_slot][0] <= req.pos_x;
              vp[req.vertex_slot][1] <= req.pos_y;
              vp[req.vertex_slot][2] <= req.pos_z;
              vf[req.vertex_slot][0] <= req.fld_x;
              vf[req.vertex_slot][1] <= req.fld_y;
              vf[req.vertex_slot][2] <= req.fld_z;
            end else begin
              qp[0]   <= req.pos_x;
              qp[1]   <= req.pos_y;
              qp[2]   <= req.pos_z;
              det_idx <= '0;
              fmode   <= 1'b0;
              in_tet  <= 1'b1;
              sat     <= 1'b0;
              degen   <= 1'b0;
              for (int c = 0; c < 3; c++) fo[c] <= '0;
            end
          end
        end
        ST_EDGES: begin
          e       <= e_next;
          cof     <= '0;
          phase   <= PH_COF_A;
          det_run <= '0;
        end
        ST_MAC_WAIT: begin
          if (mac_done) begin
            if (fmode) begin
              vtx <= vtx + 2'd1;
            end else begin
              unique case (phase)
                PH_COF_A: phase <= PH_COF_B;
                PH_COF_B: begin
                  s_reg <= acc[DET_W-1:0];
                  phase <= PH_TERM;
                end
                default: begin
                  det_run <= acc[DET_W-1:0];
                  phase   <= PH_COF_A;
                  cof     <= cof + 2'd1;
                end
              endcase
            end
          end
        end
        ST_DET_END: begin
          if (det_idx == 3'd0) begin
            dv    <= acc[DET_W-1:0];
            degen <= degen_now;
          end else begin
            di[dsel] <= acc[DET_W-1:0];
            if (acc != '0 && acc[ACC_W-1] != dv[DET_W-1]) in_tet <= 1'b0;
          end
          det_idx <= det_idx + 3'd1;
          if (det_idx == 3'd4) begin
            fmode <= 1'b1;
            vtx   <= '0;
            comp  <= '0;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            fo[comp] <= clip_val;
            sat      <= sat | clip_sat;
            comp     <= comp + 2'd1;
            vtx      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_degen_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
      (result.field_x == '0 && result.field_y == '0 && result.field_z == '0 &&
       !result.inside_res && !result.saturated))
    else $error("degenerate result carries field data");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!mac_cmd.start && !div_cmd.start))
    else $error("arithmetic unit started while idle");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench for the tetrahedral interpolation unit
// A short table of vertex loads and point queries covers the corner cases
// first: flat tetrahedra, vertex hits, far extrapolation and saturation.
// Random tetrahedra and queries follow under several volume cut settings.
// Each query result is checked against an exact 128-bit barycentric
// calculation done in the bench, or against an expected result in the table.
// ----------------------------------------------------------------------------
module tb;
  import tbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    req_t r;
    bit   typed;
    res_t e;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  req_t                req = '0;
  logic                cfg_we = 1'b0;
  logic [CUT_BITS-1:0] cfg_data = '0;
  logic                done;
  res_t                result;

  req_t                vtx_store[4];
  logic [CUT_BITS-1:0] cut_model = '0;
  res_t                pending_fields[$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  int                  n_items = 0, n_query = 0, n_degen = 0, n_inside = 0, n_sat = 0;

  tetra_barycentric_interp_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic wide_t six_volume(wide_t p[4][3]);
    wide_t e[3][3];
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < 3; k++)
        e[c][k] = p[c+1][k] - p[0][k];
    return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
         - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
         + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
  endfunction

  function automatic res_t interpolate(req_t q);
    wide_t p[4][3], s[4][3], fl[3][4];
    wide_t vol, avol, di[4], acc, quo;
    wide_t lim_hi, lim_lo;
    res_t  o;
    o = '0;
    lim_hi = (128'sd1 <<< (FIELD_BITS - 1)) - 1;
    lim_lo = -(128'sd1 <<< (FIELD_BITS - 1));
    for (int i = 0; i < 4; i++) begin
      p[i][0] = wide_t'(vtx_store[i].pos_x);
      p[i][1] = wide_t'(vtx_store[i].pos_y);
      p[i][2] = wide_t'(vtx_store[i].pos_z);
      fl[0][i] = wide_t'(vtx_store[i].fld_x);
      fl[1][i] = wide_t'(vtx_store[i].fld_y);
      fl[2][i] = wide_t'(vtx_store[i].fld_z);
    end
    vol = six_volume(p);
    avol = (vol < 0) ? -vol : vol;
    if (avol <= wide_t'({80'd0, cut_model})) begin
      o.degenerate = 1'b1;
      return o;
    end
    o.inside_res = 1'b1;
    for (int i = 0; i < 4; i++) begin
      s = p;
      s[i][0] = wide_t'(q.pos_x);
      s[i][1] = wide_t'(q.pos_y);
      s[i][2] = wide_t'(q.pos_z);
      di[i] = six_volume(s);
      if (di[i] != 0 && ((di[i] < 0) != (vol < 0))) o.inside_res = 1'b0;
    end
    for (int c = 0; c < 3; c++) begin
      acc = '0;
      for (int i = 0; i < 4; i++) acc += di[i] * fl[c][i];
      quo = acc / vol;
      if (quo > lim_hi) begin
        quo = lim_hi;
        o.saturated = 1'b1;
      end
      if (quo < lim_lo) begin
        quo = lim_lo;
        o.saturated = 1'b1;
      end
      case (c)
        0: o.field_x = quo[FIELD_BITS-1:0];
        1: o.field_y = quo[FIELD_BITS-1:0];
        default: o.field_z = quo[FIELD_BITS-1:0];
      endcase
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // request accepted at an edge where start is high and busy low
  task automatic send(req_t r, bit typed = 0, res_t e = '0);
    res_t o;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    n_items++;
    if (r.req_type == REQ_LOAD) begin
      vtx_store[r.vertex_slot] = r;
    end else begin
      o = interpolate(r);
      n_query++;
      n_degen += int'(o.degenerate);
      n_inside += int'(o.inside_res);
      n_sat += int'(o.saturated);
      pending_fields.insert(pending_fields.size(), typed ? e : o);
    end
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int rnd_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending_fields.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cut(logic [CUT_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cut_model = v;
  endtask

  function automatic logic [23:0] rnd_val(int mode);
    case (mode)
      0: return 24'($signed($urandom_range(0, 2000)) - 1000);
      1: return 24'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          3: return 24'hFFFFFF;
          default: return 24'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic req_t rnd_req(logic kind, logic [1:0] slot, int mode);
    req_t r;
    r.req_type = kind;
    r.vertex_slot = slot;
    r.pos_x = rnd_val(mode);
    r.pos_y = rnd_val(mode);
    r.pos_z = rnd_val(mode);
    r.fld_x = rnd_val($urandom_range(0, 2));
    r.fld_y = rnd_val($urandom_range(0, 2));
    r.fld_z = rnd_val($urandom_range(0, 2));
    return r;
  endfunction

  function automatic req_t mk(logic kind, int slot, int px, int py, int pz,
                              int fx, int fy, int fz);
    return '{kind, 2'(slot), 24'(px), 24'(py), 24'(pz), 24'(fx), 24'(fy), 24'(fz)};
  endfunction

  function automatic int pick_mode();
    int k;
    k = $urandom_range(0, 99);
    return (k < 60) ? 0 : (k < 85) ? 1 : 2;
  endfunction

  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 6000) begin
        $display("timeout: no request or result for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
      if (done) begin
        if (pending_fields.size() == 0) begin
          report("unexpected result", 32'(result), 32'd0);
        end else begin
          w = pending_fields.pop_front();
          if (result.field_x !== w.field_x)
            report("field_x", 32'(result.field_x), 32'(w.field_x));
          if (result.field_y !== w.field_y)
            report("field_y", 32'(result.field_y), 32'(w.field_y));
          if (result.field_z !== w.field_z)
            report("field_z", 32'(result.field_z), 32'(w.field_z));
          if (result.inside_res !== w.inside_res)
            report("inside_res", 32'(result.inside_res), 32'(w.inside_res));
          if (result.degenerate !== w.degenerate)
            report("degenerate", 32'(result.degenerate), 32'(w.degenerate));
          if (result.saturated !== w.saturated)
            report("saturated", 32'(result.saturated), 32'(w.saturated));
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    res_t flat;
    int   mode, nq;
    logic [CUT_BITS-1:0] cuts[4];
    for (int i = 0; i < 4; i++) vtx_store[i] = '0;
    flat = '0;
    flat.degenerate = 1'b1;

    for (int i = 0; i < 4; i++)
      rows.insert(rows.size(), '{mk(REQ_LOAD, i, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 0, 5, 5, 5, 0, 0, 0), 1'b1, flat});
    rows.insert(rows.size(), '{mk(REQ_LOAD, 0, 0, 0, 0, 100, 200, -300), 1'b0, '0});
    rows.insert(rows.size(),
                '{mk(REQ_LOAD, 1, 1000, 0, 0, 8388607, -8388608, 7), 1'b0, '0});
    rows.insert(rows.size(),
                '{mk(REQ_LOAD, 2, 0, 1000, 0, -8388608, 8388607, -1), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_LOAD, 3, 0, 0, 1000, 0, 1, 8388607), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 3, 250, 250, 250, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 1, 500, 500, 0, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 2, -1, 300, 300, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(),
                '{mk(REQ_QUERY, 3, 8388607, 8388607, 8388607, -1, -1, -1), 1'b0, '0});
    rows.insert(rows.size(),
                '{mk(REQ_QUERY, 0, -8388608, -8388608, -8388608, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(),
                '{mk(REQ_LOAD, 1, 8388607, -8388608, 0, -1, -1, -1), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_LOAD, 2, -8388608, 8388607, -8388608,
                                  8388607, 8388607, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_LOAD, 3, 0, 8388607, 8388607,
                                  -8388608, 0, -8388608), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 1, 1, -1, 1, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(),
                '{mk(REQ_QUERY, 2, 8388607, -8388608, 8388607, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_LOAD, 3, 4000000, 0, -8388608, 0, 0, 0), 1'b0, '0});
    rows.insert(rows.size(), '{mk(REQ_QUERY, 3, 0, 0, 0, 0, 0, 0), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].r, rows[i].typed, rows[i].e);
      pause(rnd_gap());
    end

    cuts[0] = '0;
    cuts[1] = 48'(($urandom_range(1, 1000) * 64'd1) << 20);
    cuts[2] = {16'($urandom_range(0, 65535)), 32'($urandom)};
    cuts[3] = '1;
    for (int ph = 0; ph < 4; ph++) begin
      set_cut(cuts[ph]);
      while (n_items < 24 + (ph + 1) * 460) begin
        if ($urandom_range(0, 99) < 80) begin
          mode = pick_mode();
          for (int s = 0; s < 4; s++) begin
            send(rnd_req(REQ_LOAD, 2'(s), mode));
            pause(rnd_gap());
          end
          nq = $urandom_range(1, 4);
          for (int k = 0; k < nq; k++) begin
            send(rnd_req(REQ_QUERY, 2'($urandom), mode));
            pause(rnd_gap());
          end
        end else begin
          send(rnd_req(1'($urandom), 2'($urandom), pick_mode()));
          pause(rnd_gap());
        end
      end
    end

    start <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    $display("%0d requests, %0d queries under 4 volume cut settings", n_items, n_query);
    $display("%0d flat, %0d inside, %0d clipped results", n_degen, n_inside, n_sat);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
